/* rtl/idxdq_pkg.sv */
// Shared types and constants for the indexed deque with listing.
`default_nettype none
package idxdq_pkg;

  localparam int DATA_W = 32;
  localparam int MODE_W = 2;

  localparam logic [MODE_W-1:0] MODE_ADD_HEAD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD_TAIL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE   = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE     = 2'd0,
    OP_ADD_HEAD = 2'd1,
    OP_ADD_TAIL = 2'd2,
    OP_DELETE   = 2'd3
  } op_kind_t;

endpackage
`default_nettype wire

/* rtl/idxdq_cell.sv */
// One storage cell of the deque chain: holds one entry, shifts with its neighbors.
`default_nettype none
module idxdq_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  wire                           clk,
  input  wire idxdq_pkg::op_kind_t      op,
  input  wire  [CNT_W-1:0]              pos,
  input  wire  [CNT_W-1:0]              cnt,
  input  wire  [idxdq_pkg::DATA_W-1:0]  operand,
  input  wire  [idxdq_pkg::DATA_W-1:0]  left_data,
  input  wire  [idxdq_pkg::DATA_W-1:0]  right_data,
  output logic [idxdq_pkg::DATA_W-1:0]  data
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [idxdq_pkg::DATA_W-1:0] data_r;
  logic [idxdq_pkg::DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (op)
      idxdq_pkg::OP_ADD_HEAD: data_nxt = left_data;
      idxdq_pkg::OP_ADD_TAIL: begin
        if (cnt == MY_IDX) data_nxt = operand;
      end
      idxdq_pkg::OP_DELETE: begin
        if (MY_IDX >= pos) data_nxt = right_data;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule
`default_nettype wire

/* rtl/indexed_deque_with_listing_unit.sv */
// Top level of the indexed deque with listing: request control, cell chain, listing.
// Each request beat is accepted in ST_IDLE, applied to the cell chain in the next cycle
// (ST_UPDATE), and then listed one beat per cycle while out_tready is high: 2*count beats
// (head to tail, then tail to head), or two empty markers when the list is empty. No new
// request is accepted until the last beat of that listing is taken. A push into a full
// list is dropped and flagged with overflow on every beat of its listing.
`default_nettype none
module indexed_deque_with_listing_unit #(
  parameter int CAPACITY = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // [31:0] operand
  input  wire  [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,  // [31:0] element
  output logic [3:0]  out_tuser,  // [0] direction, [1] list_empty, [2] last_in_direction,
                                  // [3] overflow
  output logic        out_tlast   // last beat of this request
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_UPDATE = 3'b010,
    ST_LIST   = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [CNT_W-1:0]              pos_r, pos_nxt;
  logic                          dir_r, dir_nxt;
  logic                          ovf_r, ovf_nxt;
  logic [idxdq_pkg::MODE_W-1:0]  mode_r;
  logic [idxdq_pkg::DATA_W-1:0]  opnd_r;

  idxdq_pkg::op_kind_t           op;
  logic [CNT_W-1:0]              del_pos;
  logic                          del_ok;
  logic                          list_empty;
  logic                          last_dir;
  logic                          out_beat;

  logic [idxdq_pkg::DATA_W-1:0]  cell_q [CAPACITY];

  // cell chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [idxdq_pkg::DATA_W-1:0] left_d;
    logic [idxdq_pkg::DATA_W-1:0] right_d;
    if (g == 0) begin : g_head
      assign left_d = opnd_r;
    end else begin : g_mid_l
      assign left_d = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_d = cell_q[g];
    end else begin : g_mid_r
      assign right_d = cell_q[g+1];
    end
    idxdq_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .pos        (del_pos),
      .cnt        (count_r),
      .operand    (opnd_r),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_q[g])
    );
  end

  assign del_pos = opnd_r[CNT_W-1:0];
  assign del_ok  = !opnd_r[idxdq_pkg::DATA_W-1] &&
                   ({{(idxdq_pkg::DATA_W-CNT_W){1'b0}}, count_r} > opnd_r);

  always_comb begin
    op = idxdq_pkg::OP_NONE;
    if (state_r == ST_UPDATE) begin
      unique case (mode_r)
        idxdq_pkg::MODE_ADD_HEAD: if (count_r < CAP_C) op = idxdq_pkg::OP_ADD_HEAD;
        idxdq_pkg::MODE_ADD_TAIL: if (count_r < CAP_C) op = idxdq_pkg::OP_ADD_TAIL;
        idxdq_pkg::MODE_DELETE:   if (del_ok) op = idxdq_pkg::OP_DELETE;
        default:                  op = idxdq_pkg::OP_NONE;
      endcase
    end
  end

  assign list_empty = (count_r == '0);
  assign last_dir   = list_empty ? 1'b1
                    : (dir_r ? (pos_r == '0) : (pos_r == count_r - ONE_C));
  assign out_beat   = out_tvalid && out_tready;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_LIST);
  assign out_tdata  = list_empty ? '0 : cell_q[pos_r[IDX_W-1:0]];
  assign out_tuser  = {ovf_r, last_dir, list_empty, dir_r};
  assign out_tlast  = dir_r && last_dir;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    dir_nxt   = dir_r;
    ovf_nxt   = ovf_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        ovf_nxt = ((mode_r == idxdq_pkg::MODE_ADD_HEAD) ||
                   (mode_r == idxdq_pkg::MODE_ADD_TAIL)) && (count_r >= CAP_C);
        case (op) inside
          idxdq_pkg::OP_ADD_HEAD, idxdq_pkg::OP_ADD_TAIL: count_nxt = count_r + ONE_C;
          idxdq_pkg::OP_DELETE:                           count_nxt = count_r - ONE_C;
          default:                                        count_nxt = count_r;
        endcase
        pos_nxt   = '0;
        dir_nxt   = 1'b0;
        state_nxt = ST_LIST;
      end
      ST_LIST: begin
        if (out_beat) begin
          if (last_dir) begin
            if (dir_r) begin
              state_nxt = ST_IDLE;
            end else begin
              dir_nxt = 1'b1;
              pos_nxt = list_empty ? '0 : count_r - ONE_C;
            end
          end else if (dir_r) begin
            pos_nxt = pos_r - ONE_C;
          end else begin
            pos_nxt = pos_r + ONE_C;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      pos_r   <= '0;
      dir_r   <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pos_r   <= pos_nxt;
      dir_r   <= dir_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      mode_r <= in_tuser;
      opnd_r <= in_tdata;
    end
  end

endmodule
`default_nettype wire
